[hdl/assert_macros.svh]
// Assertion macros shared by the S-box RTL.
// No dependencies; each macro expands to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SBOX_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sbox assertion failed");
`define SBOX_ASSERT_IMPL(lbl, ante, cons) \
    `SBOX_ASSERT(lbl, (ante) |-> (cons))
`define SBOX_ASSERT_NEXT(lbl, ante, cons) \
    `SBOX_ASSERT(lbl, (ante) |=> (cons))
`else
`define SBOX_ASSERT(lbl, prop)
`define SBOX_ASSERT_IMPL(lbl, ante, cons)
`define SBOX_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/sbox_pkg.sv]
// Package for the AES S-box: GF(2^8) constants, reduction, squaring and affine maps.
// No dependencies.
package sbox_pkg;

    localparam int unsigned GfBits = 8;
    localparam int unsigned ProdBits = 2 * GfBits - 1;

    // x^8 + x^4 + x^3 + x + 1
    localparam logic [GfBits:0]   GF_POLY        = 9'h11B;
    localparam logic [GfBits-1:0] AFFINE_ADD     = 8'h63;
    localparam logic [GfBits-1:0] AFFINE_INV_ADD = 8'h05;

    // Operation selector carried in tuser
    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    typedef logic [GfBits-1:0]   t_byte;
    typedef logic [ProdBits-1:0] t_prod;

    // Fold a carry-less product back into the field, top bit first
    function automatic t_byte gf_reduce(input t_prod p);
        t_prod acc;
        acc = p;
        for (int k = ProdBits - 1; k >= GfBits; k--) begin
            if (acc[k]) begin
                acc = acc ^ (t_prod'(GF_POLY) << (k - GfBits));
            end
        end
        return acc[GfBits-1:0];
    endfunction

    // Squaring is linear: spread bit i to bit 2i, then reduce
    function automatic t_byte gf_square(input t_byte a);
        t_prod s;
        s = '0;
        for (int i = 0; i < GfBits; i++) begin
            s[2*i] = a[i];
        end
        return gf_reduce(s);
    endfunction

    function automatic t_byte rol(input t_byte b, input int unsigned k);
        return t_byte'((b << k) | (b >> (GfBits - k)));
    endfunction

    function automatic t_byte affine_fwd(input t_byte b);
        return b ^ rol(b, 1) ^ rol(b, 2) ^ rol(b, 3) ^ rol(b, 4) ^ AFFINE_ADD;
    endfunction

    function automatic t_byte affine_inv(input t_byte s);
        return rol(s, 1) ^ rol(s, 3) ^ rol(s, 6) ^ AFFINE_INV_ADD;
    endfunction

endpackage

[hdl/sbox_gf_mul.sv]
// GF(2^8) multiplier, combinational, reduced by the AES polynomial.
// Depends on sbox_pkg.
module sbox_gf_mul import sbox_pkg::*; (
    input  t_byte i_a,
    input  t_byte i_b,
    output t_byte o_p
);

    t_prod prod;

    // Carry-less partial products, then one reduction
    always_comb begin
        prod = '0;
        for (int i = 0; i < GfBits; i++) begin
            if (i_b[i]) begin
                prod = prod ^ (t_prod'(i_a) << i);
            end
        end
    end

    assign o_p = gf_reduce(prod);

endmodule

[hdl/aes_sbox_forward_inverse.sv]
// AES S-box, forward and inverse, by GF(2^8) inversion (a^254) and the affine map.
// Depends on sbox_pkg, sbox_gf_mul and assert_macros.svh.
//
// Usage:
//   Input stream: i_s_tdata[7:0] is the byte, i_s_tuser[0] the operation
//   (0 forward, 1 inverse). A beat is taken when i_s_tvalid and o_s_tready.
//   Output stream: o_m_tdata[7:0] is the substituted byte, taken when
//   o_m_tvalid and i_m_tready.
//   An accepted input beat moves through r_v1, r_v2 and r_v3 to o_m_tvalid,
//   when the input skid is empty. Throughput: one byte per cycle while the
//   receiver keeps i_m_tready high.
//   The inversion runs as a three-stage chain of field multipliers
//   (a^3; a^14 and a^15; a^254), one multiplier depth per stage; that
//   stage depth sets the clock.
//   When the receiver stalls, the whole pipe holds and one further beat
//   lands in a single-entry input skid; o_s_tready is a register output
//   and drops while that skid is full.
//   Reset (synchronous, active low) clears all valid bits, the skid and
//   o_s_tready; the payload registers are not reset.
`include "assert_macros.svh"

module aes_sbox_forward_inverse import sbox_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] value_in
    input  logic [0:0] i_s_tuser,   // [0] operation
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [7:0] value_out
);

    // Input skid
    logic  r_skid_v, n_skid_v;
    logic  r_skid_op;
    t_byte r_skid_val;
    logic  r_s_tready;

    // Pipeline stages
    logic  r_v1, r_v2, r_v3;
    logic  r1_op, r2_op;
    t_byte r1_a2, r1_a3;
    t_byte r2_a14, r2_a15;
    t_byte r3_out;

    logic  en;
    logic  s_acc;
    logic  f_v, f_op;
    t_byte f_val, f_a, f_a2;
    t_byte m1_a3, a12, m2_a14, m2_a15, a240, m3_inv;

    assign o_s_tready = r_s_tready;
    assign s_acc      = i_s_tvalid && r_s_tready;
    assign en         = !r_v3 || i_m_tready;

    // Feed: skid first, else the port
    assign f_v   = r_skid_v || s_acc;
    assign f_op  = r_skid_v ? r_skid_op  : i_s_tuser[0];
    assign f_val = r_skid_v ? r_skid_val : i_s_tdata;

    always_comb begin
        n_skid_v = r_skid_v;
        if (en) begin
            n_skid_v = 1'b0;
        end else if (s_acc) begin
            n_skid_v = 1'b1;
        end
    end

    // Stage 1: undo affine for inverse, then a^2 and a^3
    assign f_a  = (f_op == OP_INVERSE) ? affine_inv(f_val) : f_val;
    assign f_a2 = gf_square(f_a);

    sbox_gf_mul u_mul1 (.i_a(f_a2), .i_b(f_a), .o_p(m1_a3));

    // Stage 2: a^12 by two squarings, then a^14 and a^15
    assign a12 = gf_square(gf_square(r1_a3));

    sbox_gf_mul u_mul2a (.i_a(a12), .i_b(r1_a2), .o_p(m2_a14));
    sbox_gf_mul u_mul2b (.i_a(a12), .i_b(r1_a3), .o_p(m2_a15));

    // Stage 3: a^240 by four squarings, a^254 = a^240 * a^14
    assign a240 = gf_square(gf_square(gf_square(gf_square(r2_a15))));

    sbox_gf_mul u_mul3 (.i_a(a240), .i_b(r2_a14), .o_p(m3_inv));

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v   <= 1'b0;
            r_s_tready <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
        end else begin
            r_skid_v   <= n_skid_v;
            r_s_tready <= !n_skid_v;
            if (en) begin
                r_v1 <= f_v;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (!en && s_acc) begin
            r_skid_op  <= i_s_tuser[0];
            r_skid_val <= i_s_tdata;
        end
        if (en) begin
            r1_op  <= f_op;
            r1_a2  <= f_a2;
            r1_a3  <= m1_a3;
            r2_op  <= r1_op;
            r2_a14 <= m2_a14;
            r2_a15 <= m2_a15;
            r3_out <= (r2_op == OP_FORWARD) ? affine_fwd(m3_inv) : m3_inv;
        end
    end

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r3_out;

    // Checks
    `SBOX_ASSERT_NEXT(a_stall_holds_mid, !en && r_v2, r_v2)
    `SBOX_ASSERT_IMPL(a_skid_fills_on_stall, $rose(r_skid_v), $past(!en))
    `SBOX_ASSERT_NEXT(a_zero_inverse, en && r_v1 && (r1_a3 == '0), r2_a15 == '0)

endmodule
